// ===== sv/tlv_stream_deframer_assert.svh =====
// assertion macros used by the deframer checker
`ifndef TLV_STREAM_DEFRAMER_ASSERT_SVH
`define TLV_STREAM_DEFRAMER_ASSERT_SVH

// same-cycle implication, off while in reset
`define TLV_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tlv deframer: implication failed");

// next-cycle implication, off while in reset
`define TLV_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tlv deframer: next-cycle check failed");

// next-cycle implication that also holds through reset
`define TLV_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("tlv deframer: reset check failed");

`endif

// ===== sv/tlv_pkg.sv =====
// types and constants of the tlv stream deframer
`timescale 1ns / 1ps

package tlv_pkg;

    localparam int BYTE_W           = 8;
    localparam int TAG_W            = 6;
    localparam int CLS_W            = 2;
    localparam int GROUP_W          = 7;
    localparam int ERR_W            = 2;
    localparam int NUM_TAGS         = 1 << TAG_W;
    localparam int LEN_BITS_DEFAULT = 32;
    localparam int CFG_DATA_W       = 32;
    localparam int CFG_IDX_W        = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_CHECK = CFG_IDX_W'(1);

    localparam logic [CLS_W-1:0] CLS_VAR   = 2'd0;
    localparam logic [CLS_W-1:0] CLS_ONE   = 2'd1;
    localparam logic [CLS_W-1:0] CLS_FOUR  = 2'd2;
    localparam logic [CLS_W-1:0] CLS_EIGHT = 2'd3;

    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_TRUNC = 2'd1;
    localparam logic [ERR_W-1:0] ERR_CLASS = 2'd2;
    localparam logic [ERR_W-1:0] ERR_LONG  = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              message_end;
    } in_item_t;

    typedef struct packed {
        logic [TAG_W-1:0]  field_tag;
        logic [CLS_W-1:0]  size_class;
        logic [BYTE_W-1:0] payload_byte;
        logic              byte_valid;
        logic              field_last;
        logic              message_last;
        logic [ERR_W-1:0]  error_code;
    } out_item_t;

    typedef struct packed {
        logic             en;
        logic [TAG_W-1:0] tag;
        logic [CLS_W-1:0] cls;
    } tag_wr_t;

    typedef struct packed {
        logic             seen;
        logic [CLS_W-1:0] cls;
    } tag_lookup_t;

endpackage

// ===== sv/tlv_stream_deframer.sv =====
// top level of the tlv stream deframer
`timescale 1ns / 1ps

// Byte-serial tag-length-value deframer. One byte is taken per cycle, sustained,
// and its result (if any) reaches the m_ channel through a registered path: the
// accepting edge captures the byte and starts the registered read of the tag
// class memory, and a later edge, once the output register is free, stores the
// decode in the output register. That memory read is forwarded from a write to
// the same tag on the same edge. While a result waits on m_ready the byte behind
// it holds and s_ready stays low. Seen bits are flip-flops cleared all at once at
// reset and at each message end, so there is no clearing pass. Configuration
// writes are always ready and take effect from the next cycle; write them only
// while no byte is in flight.
module tlv_stream_deframer #(
    parameter int LEN_BITS = tlv_pkg::LEN_BITS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  tlv_pkg::in_item_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output tlv_pkg::out_item_t             m_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tlv_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tlv_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tlv_pkg::*;

    logic [CFG_DATA_W-1:0] max_len_reg;
    logic                  type_check_reg;

    logic        s1_valid_reg, s1_valid_next;
    in_item_t    s1_item_reg;
    logic        m_valid_reg, m_valid_next;
    out_item_t   m_data_reg;

    logic        accept;
    logic        go;
    out_item_t   res;
    logic        res_valid;
    tag_wr_t     wr;
    logic        clear;
    tag_lookup_t lookup;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg    <= '1;
            type_check_reg <= 1'b1;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_MAX_LEN:    max_len_reg    <= cfg_data;
                CFG_TYPE_CHECK: type_check_reg <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign go      = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || go;
    assign accept  = s_valid && s_ready;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (go) begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (go) begin
            m_valid_next = res_valid;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_item_reg <= s_data;
        end
        if (go && res_valid) begin
            m_data_reg <= res;
        end
    end

    tlv_tag_mem u_tag_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_tag  (s_data.data_byte[TAG_W-1:0]),
        .wr      (wr),
        .clear   (clear),
        .lookup  (lookup)
    );

    tlv_parse_core #(
        .LEN_BITS (LEN_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .go         (go),
        .item       (s1_item_reg),
        .lookup     (lookup),
        .max_len    (max_len_reg),
        .type_check (type_check_reg),
        .res        (res),
        .res_valid  (res_valid),
        .wr         (wr),
        .clear      (clear)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== sv/tlv_tag_mem.sv =====
// per-message tag class memory with seen bits and write forwarding
`timescale 1ns / 1ps

module tlv_tag_mem (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     rd_en,
    input  logic [tlv_pkg::TAG_W-1:0] rd_tag,
    input  tlv_pkg::tag_wr_t         wr,
    input  logic                     clear,
    output tlv_pkg::tag_lookup_t     lookup
);
    import tlv_pkg::*;

    logic [CLS_W-1:0]    class_mem [NUM_TAGS];
    logic [CLS_W-1:0]    rd_data_reg;
    logic [TAG_W-1:0]    rd_tag_reg;
    logic [NUM_TAGS-1:0] seen_reg;
    logic                fwd_hit_reg;
    logic [CLS_W-1:0]    fwd_cls_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            class_mem[wr.tag] <= wr.cls;
        end
        if (rd_en) begin
            rd_data_reg <= class_mem[rd_tag];
            rd_tag_reg  <= rd_tag;
            fwd_cls_reg <= wr.cls;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg    <= '0;
            fwd_hit_reg <= 1'b0;
        end else begin
            if (clear) begin
                seen_reg <= '0;
            end else if (wr.en) begin
                seen_reg[wr.tag] <= 1'b1;
            end
            // write and read of the same tag on one edge
            if (rd_en) begin
                fwd_hit_reg <= wr.en && (wr.tag == rd_tag);
            end
        end
    end

    assign lookup.seen = seen_reg[rd_tag_reg];
    assign lookup.cls  = fwd_hit_reg ? fwd_cls_reg : rd_data_reg;

endmodule

// ===== sv/tlv_parse_core.sv =====
// field parser: header decode, length groups, payload count, drop
`timescale 1ns / 1ps

module tlv_parse_core #(
    parameter int LEN_BITS = tlv_pkg::LEN_BITS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         go,
    input  tlv_pkg::in_item_t            item,
    input  tlv_pkg::tag_lookup_t         lookup,
    input  logic [tlv_pkg::CFG_DATA_W-1:0] max_len,
    input  logic                         type_check,
    output tlv_pkg::out_item_t           res,
    output logic                         res_valid,
    output tlv_pkg::tag_wr_t             wr,
    output logic                         clear
);
    import tlv_pkg::*;

    localparam int CMP_W = (LEN_BITS > CFG_DATA_W) ? LEN_BITS : CFG_DATA_W;

    typedef enum logic [3:0] {
        PH_HEADER  = 4'b0001,
        PH_LENGTH  = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_DROP    = 4'b1000
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [TAG_W-1:0]    tag_reg, tag_next;
    logic [CLS_W-1:0]    cls_reg, cls_next;
    logic [LEN_BITS-1:0] acc_reg, acc_next;
    logic [LEN_BITS-1:0] rem_reg, rem_next;

    logic [BYTE_W-1:0]   b;
    logic                mend;
    logic [TAG_W-1:0]    hdr_tag;
    logic [CLS_W-1:0]    hdr_cls;
    logic                more;
    logic [LEN_BITS-1:0] acc_shift;
    logic                acc_ovf;
    logic                acc_big;
    logic [LEN_BITS-1:0] rem_left;

    always_comb begin
        b         = item.data_byte;
        mend      = item.message_end;
        hdr_tag   = b[TAG_W-1:0];
        hdr_cls   = b[BYTE_W-1 -: CLS_W];
        more      = b[BYTE_W-1];
        acc_shift = {acc_reg[LEN_BITS-GROUP_W-1:0], b[GROUP_W-1:0]};
        acc_ovf   = acc_reg[LEN_BITS-1 -: GROUP_W] != '0;
        acc_big   = CMP_W'(acc_shift) > CMP_W'(max_len);
        rem_left  = (rem_reg != '0) ? rem_reg - LEN_BITS'(1) : '0;
    end

    always_comb begin
        phase_next = phase_reg;
        tag_next   = tag_reg;
        cls_next   = cls_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;

        res_valid        = 1'b0;
        res.field_tag    = tag_reg;
        res.size_class   = cls_reg;
        res.payload_byte = '0;
        res.byte_valid   = 1'b0;
        res.field_last   = 1'b1;
        res.message_last = mend;
        res.error_code   = ERR_NONE;

        wr.en  = 1'b0;
        wr.tag = hdr_tag;
        wr.cls = hdr_cls;

        case (phase_reg)
            PH_HEADER: begin
                tag_next       = hdr_tag;
                cls_next       = hdr_cls;
                acc_next       = '0;
                res.field_tag  = hdr_tag;
                res.size_class = hdr_cls;
                if (mend) begin
                    res_valid      = 1'b1;
                    res.error_code = ERR_TRUNC;
                end else if (type_check && lookup.seen && (lookup.cls != hdr_cls)) begin
                    res_valid      = 1'b1;
                    res.error_code = ERR_CLASS;
                    phase_next     = PH_DROP;
                end else begin
                    wr.en = !lookup.seen;
                    if (hdr_cls == CLS_VAR) begin
                        phase_next = PH_LENGTH;
                    end else begin
                        case (hdr_cls)
                            CLS_ONE:  rem_next = LEN_BITS'(1);
                            CLS_FOUR: rem_next = LEN_BITS'(4);
                            default:  rem_next = LEN_BITS'(8);
                        endcase
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_LENGTH: begin
                if (acc_ovf) begin
                    res_valid      = 1'b1;
                    res.error_code = ERR_LONG;
                    phase_next     = PH_DROP;
                end else begin
                    acc_next = acc_shift;
                    if (!more && acc_big) begin
                        res_valid      = 1'b1;
                        res.error_code = ERR_LONG;
                        phase_next     = PH_DROP;
                    end else if (more) begin
                        if (mend) begin
                            res_valid      = 1'b1;
                            res.error_code = ERR_TRUNC;
                        end
                    end else if (acc_shift == '0) begin
                        res_valid  = 1'b1;
                        phase_next = PH_HEADER;
                    end else if (mend) begin
                        res_valid      = 1'b1;
                        res.error_code = ERR_TRUNC;
                    end else begin
                        rem_next   = acc_shift;
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                rem_next  = rem_left;
                res_valid = 1'b1;
                if (mend && (rem_left != '0)) begin
                    res.error_code = ERR_TRUNC;
                end else begin
                    res.payload_byte = b;
                    res.byte_valid   = 1'b1;
                    res.field_last   = (rem_left == '0);
                    if (rem_left == '0) begin
                        phase_next = PH_HEADER;
                    end
                end
            end
            PH_DROP: begin
                phase_next = PH_DROP;
            end
            default: begin
                phase_next = PH_HEADER;
            end
        endcase

        if (mend) begin
            phase_next = PH_HEADER;
            acc_next   = '0;
            rem_next   = '0;
        end

        wr.en = wr.en && go;
    end

    assign clear = go && mend;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            tag_reg   <= '0;
            cls_reg   <= '0;
            acc_reg   <= '0;
            rem_reg   <= '0;
        end else if (go) begin
            phase_reg <= phase_next;
            tag_reg   <= tag_next;
            cls_reg   <= cls_next;
            acc_reg   <= acc_next;
            rem_reg   <= rem_next;
        end
    end

endmodule

// ===== sv/tlv_checker.sv =====
// port-level checker for the tlv stream deframer and its bind
`timescale 1ns / 1ps
`include "tlv_stream_deframer_assert.svh"

module tlv_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input tlv_pkg::out_item_t m_data,
    input logic               cfg_valid,
    input logic               cfg_ready
);
    import tlv_pkg::*;

    `TLV_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `TLV_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid)
    `TLV_ASSERT_IMPLY(a_err_closes, aclk, aresetn, m_valid && (m_data.error_code != ERR_NONE), m_data.field_last && !m_data.byte_valid)
    `TLV_ASSERT_IMPLY(a_cfg_ready, aclk, aresetn, cfg_valid, cfg_ready)

endmodule

bind tlv_stream_deframer tlv_checker u_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
